[rtl/compacting_ordered_list_core_defines.svh]
// ----------------------------------------------------------------------------
// compacting ordered list core - assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_ORDERED_LIST_CORE_DEFINES_SVH
`define COMPACTING_ORDERED_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define COLC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("colc: invariant violated");
// consequent holds in the cycle after the antecedent
`define COLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("colc: sequence check failed");
`else
`define COLC_ASSERT(lbl, expr)
`define COLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/colc_pkg.sv]
// ----------------------------------------------------------------------------
// colc_pkg
// Command, status and cell control types of the compacting ordered list.
// ----------------------------------------------------------------------------
package colc_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_DEL_POS = 2'd1,
    CMD_DEL_VAL = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_APPEND,
    COP_DEL_POS,
    COP_DEL_VAL,
    COP_ROTATE
  } cell_op_t;

  // per-cell control, derived from the cell index and the occupancy
  typedef struct packed {
    cell_op_t op;
    logic     valid;      // index below occupancy
    logic     tail;       // index is occupancy - 1
    logic     free_slot;  // index equals occupancy
    logic     past_pos;   // index at or after the deleted position
  } cell_ctrl_t;

endpackage

[rtl/colc_in_if.sv]
// ----------------------------------------------------------------------------
// colc_in_if
// Command request channel: valid/ready with cmd, value and position.
// ----------------------------------------------------------------------------
interface colc_in_if #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [CNT_W-1:0]              position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

[rtl/colc_out_if.sv]
// ----------------------------------------------------------------------------
// colc_out_if
// Result channel: valid/ready with status, entry, flags and entry count.
// ----------------------------------------------------------------------------
interface colc_out_if #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic signed [VALUE_WIDTH-1:0] entry_value;
  logic                          has_entry;
  logic                          last;
  logic [CNT_W-1:0]              entry_count;

  modport source (output valid, output status, output entry_value, output has_entry,
                  output last, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_value, input has_entry,
                  input last, input entry_count, output ready);
endinterface

[rtl/colc_cell.sv]
// ----------------------------------------------------------------------------
// colc_cell
// One list slot: holds an entry, matches it, takes its right neighbor's value.
// ----------------------------------------------------------------------------
module colc_cell
  import colc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic [VALUE_WIDTH-1:0] head_value,
  input  logic                   found_in,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   found_out
);

  logic [VALUE_WIDTH-1:0] value_r;
  logic [VALUE_WIDTH-1:0] value_nxt;
  logic                   match;

  assign match     = ctrl.valid && (value_r == in_value);
  assign found_out = found_in | match;
  assign value_o   = value_r;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      COP_APPEND: begin
        if (ctrl.free_slot) value_nxt = in_value;
      end
      COP_DEL_POS: begin
        if (ctrl.valid && ctrl.past_pos && !ctrl.tail) value_nxt = right_value;
      end
      COP_DEL_VAL: begin
        // close the gap from the first match toward the tail
        if (ctrl.valid && found_out && !ctrl.tail) value_nxt = right_value;
      end
      COP_ROTATE: begin
        if (ctrl.tail) value_nxt = head_value;
        else if (ctrl.valid) value_nxt = right_value;
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[rtl/colc_obuf.sv]
// ----------------------------------------------------------------------------
// colc_obuf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module colc_obuf #(
  parameter int W = 41
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic [W-1:0] slot0_r;
  logic [W-1:0] slot0_nxt;
  logic [W-1:0] slot1_r;
  logic [W-1:0] slot1_nxt;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) slot0_nxt = push_data;
        else slot1_nxt = push_data;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

[rtl/compacting_ordered_list_core.sv]
// ----------------------------------------------------------------------------
// compacting_ordered_list_core
// Ordered list of up to DEPTH signed values held packed in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per request: append, delete at a 1-based
//   position, delete the first matching value, or read out the list.
//   out_ch returns the results; append and deletes give one result, a
//   read-out gives one result per entry (last set on the tail) or a single
//   empty result when the list is empty.
//   Edits complete in the cycle the request is taken: every cell decides
//   locally whether to load, take its right neighbor or hold, so one edit
//   per cycle is sustained while in_ch.ready is high; the result shows on
//   out_ch the next cycle unless an earlier result still waits in the buffer.
//   A read-out rotates the cell row one step per cycle while the buffer has
//   room and emits the head; no request is taken until the last entry is
//   buffered. A two-entry output buffer lets requests be taken while a result
//   waits; in_ch.ready drops only when it is full or a read-out is running,
//   and the rotation pauses while the buffer is full and the receiver stalls.
//   Reset empties the list at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "compacting_ordered_list_core_defines.svh"

module compacting_ordered_list_core
  import colc_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  colc_in_if.sink   in_ch,
  colc_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = 2 + VALUE_WIDTH + 1 + 1 + CNT_W;

  logic [CNT_W-1:0]       occ_r;
  logic [CNT_W-1:0]       occ_nxt;
  logic                   reading_r;
  logic                   reading_nxt;
  logic [CNT_W-1:0]       rd_left_r;
  logic [CNT_W-1:0]       rd_left_nxt;

  cmd_t                   cmd;
  logic                   accept;
  logic                   list_full;
  logic                   pos_ok;
  logic                   found;
  logic                   buf_full;
  logic                   buf_valid;
  logic                   pop;
  logic                   room;
  logic                   push;
  logic [RES_W-1:0]       push_data;
  logic [RES_W-1:0]       buf_data;
  cell_op_t               cop;

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH:0]         found_w;

  assign cmd       = cmd_t'(in_ch.cmd);
  assign in_ch.ready = !reading_r && !buf_full;
  assign accept    = in_ch.valid && in_ch.ready;
  assign list_full = (occ_r == CNT_W'(DEPTH));
  assign pos_ok    = (in_ch.position != '0) && (in_ch.position <= occ_r);
  assign found     = found_w[DEPTH];
  assign pop       = buf_valid && out_ch.ready;
  assign room      = !buf_full || pop;

  // ---- cell row ----
  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);
    cell_ctrl_t             ctrl;
    logic [VALUE_WIDTH-1:0] right_value;

    assign ctrl.op        = cop;
    assign ctrl.valid     = (IDX < occ_r);
    assign ctrl.tail      = (IDX == occ_r - CNT_W'(1));
    assign ctrl.free_slot = (IDX == occ_r);
    assign ctrl.past_pos  = (IDX1 >= in_ch.position);

    if (i == DEPTH - 1) begin : g_end
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_val[i+1];
    end

    colc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_value   (in_ch.value),
      .right_value(right_value),
      .head_value (cell_val[0]),
      .found_in   (found_w[i]),
      .value_o    (cell_val[i]),
      .found_out  (found_w[i+1])
    );
  end

  // ---- row operation ----
  always_comb begin
    cop = COP_HOLD;
    if (accept) begin
      case (cmd)
        CMD_APPEND:  if (!list_full) cop = COP_APPEND;
        CMD_DEL_POS: if (pos_ok) cop = COP_DEL_POS;
        CMD_DEL_VAL: cop = COP_DEL_VAL;
        default:     cop = COP_HOLD;
      endcase
    end else if (reading_r && room) begin
      cop = COP_ROTATE;
    end
  end

  // ---- occupancy and read-out control ----
  always_comb begin
    occ_nxt     = occ_r;
    reading_nxt = reading_r;
    rd_left_nxt = rd_left_r;
    if (accept) begin
      case (cmd)
        CMD_APPEND:  if (!list_full) occ_nxt = occ_r + CNT_W'(1);
        CMD_DEL_POS: if (pos_ok) occ_nxt = occ_r - CNT_W'(1);
        CMD_DEL_VAL: if (found) occ_nxt = occ_r - CNT_W'(1);
        CMD_READ: begin
          if (occ_r != '0) begin
            reading_nxt = 1'b1;
            rd_left_nxt = occ_r;
          end
        end
        default: occ_nxt = occ_r;
      endcase
    end else if (reading_r && room) begin
      rd_left_nxt = rd_left_r - CNT_W'(1);
      if (rd_left_r == CNT_W'(1)) reading_nxt = 1'b0;
    end
  end

  // ---- result request ----
  always_comb begin
    push      = 1'b0;
    push_data = {ST_DONE, {VALUE_WIDTH{1'b0}}, 1'b0, 1'b1, occ_nxt};
    if (accept) begin
      case (cmd)
        CMD_APPEND: begin
          push      = 1'b1;
          push_data = {(list_full ? ST_FULL : ST_DONE), {VALUE_WIDTH{1'b0}},
                       1'b0, 1'b1, occ_nxt};
        end
        CMD_DEL_POS: begin
          push      = 1'b1;
          push_data = {(pos_ok ? ST_DONE : ST_MISSING), {VALUE_WIDTH{1'b0}},
                       1'b0, 1'b1, occ_nxt};
        end
        CMD_DEL_VAL: begin
          push      = 1'b1;
          push_data = {(found ? ST_DONE : ST_MISSING), {VALUE_WIDTH{1'b0}},
                       1'b0, 1'b1, occ_nxt};
        end
        CMD_READ: begin
          // empty list answers at once
          push = (occ_r == '0);
        end
        default: push = 1'b0;
      endcase
    end else if (reading_r && room) begin
      push      = 1'b1;
      push_data = {ST_DONE, cell_val[0], 1'b1, (rd_left_r == CNT_W'(1)), occ_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      reading_r <= 1'b0;
      rd_left_r <= '0;
    end else begin
      occ_r     <= occ_nxt;
      reading_r <= reading_nxt;
      rd_left_r <= rd_left_nxt;
    end
  end

  // ---- output buffer ----
  colc_obuf #(
    .W(RES_W)
  ) u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .full     (buf_full),
    .out_valid(buf_valid),
    .out_data (buf_data)
  );

  assign out_ch.valid       = buf_valid;
  assign out_ch.status      = buf_data[RES_W-1 -: 2];
  assign out_ch.entry_value = buf_data[CNT_W+2 +: VALUE_WIDTH];
  assign out_ch.has_entry   = buf_data[CNT_W+1];
  assign out_ch.last        = buf_data[CNT_W];
  assign out_ch.entry_count = buf_data[CNT_W-1:0];

  // ---- checks ----
  `COLC_ASSERT(a_occ_bound, occ_r <= CNT_W'(DEPTH))
  `COLC_ASSERT_NEXT(a_read_start, accept && cmd == CMD_READ && occ_r != '0, reading_r)
  `COLC_ASSERT(a_read_left, !reading_r || (rd_left_r != '0 && rd_left_r <= occ_r))
  `COLC_ASSERT_NEXT(a_read_holds_occ, reading_r, occ_r == $past(occ_r))

endmodule

[tb/tb_compacting_ordered_list_core.sv]
// ----------------------------------------------------------------------------
// tb_compacting_ordered_list_core
// Drives append, delete-at-position, delete-by-value and read-out requests
// into the list core and tracks the expected list contents alongside it.
// Every result leaving the block is checked in order against the tracked
// list, first with directed edge cases, then random fill/drain traffic under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_compacting_ordered_list_core;
  import colc_pkg::*;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      has_entry;
    logic                      last;
    logic [CNT_W-1:0]          entry_count;
  } result_t;

  class list_tracker;
    logic signed [VALUE_W-1:0] slots[DEPTH];
    int                        fill;
    result_t                   pending_results[$];
    int                        errors;
    int                        n_req[4];
    int                        n_results;
    int                        n_full;
    int                        n_missing;
    int                        n_entries;

    function void close_gap(int slot);
      for (int i = slot; i + 1 < fill; i++) begin
        slots[i] = slots[i + 1];
      end
      fill--;
    endfunction

    // update the tracked list and queue the results this request causes
    function void apply_command(cmd_t c, logic signed [VALUE_W-1:0] v,
                                logic [CNT_W-1:0] p);
      result_t r;
      int      hit;
      r   = '{status: ST_DONE, entry_value: '0, has_entry: 1'b0, last: 1'b1,
              entry_count: '0};
      hit = -1;
      n_req[int'(c)]++;
      case (c)
        CMD_APPEND: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = v;
            fill++;
          end
        end
        CMD_DEL_POS: begin
          if (p >= 1 && p <= fill) close_gap(int'(p) - 1);
          else r.status = ST_MISSING;
        end
        CMD_DEL_VAL: begin
          for (int i = 0; i < fill; i++) begin
            if (slots[i] === v) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) close_gap(hit);
          else r.status = ST_MISSING;
        end
        default: begin
          for (int i = 0; i < fill; i++) begin
            r.entry_value = slots[i];
            r.has_entry   = 1'b1;
            r.last        = (i == fill - 1);
            r.entry_count = CNT_W'(fill);
            pending_results.push_back(r);
          end
        end
      endcase
      // read-out of a non-empty list has already queued its entries
      if (!(c == CMD_READ && fill > 0)) begin
        r.entry_count = CNT_W'(fill);
        pending_results.push_back(r);
      end
    endfunction

    function void match_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: unexpected result status %0d value %0d has %0b",
                    " last %0b count %0d"},
                   got.status, got.entry_value, got.has_entry, got.last, got.entry_count);
        return;
      end
      exp = pending_results.pop_front();
      n_results++;
      if (exp.status == ST_FULL) n_full++;
      if (exp.status == ST_MISSING) n_missing++;
      if (exp.has_entry) n_entries++;
      if (got.status !== exp.status || got.entry_value !== exp.entry_value ||
          got.has_entry !== exp.has_entry || got.last !== exp.last ||
          got.entry_count !== exp.entry_count) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected status %0d value %0d has %0b last %0b count %0d,",
                    " got status %0d value %0d has %0b last %0b count %0d"},
                   exp.status, exp.entry_value, exp.has_entry, exp.last, exp.entry_count,
                   got.status, got.entry_value, got.has_entry, got.last, got.entry_count);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic signed [VALUE_W-1:0] stored_value();
      return slots[$urandom_range(0, fill - 1)];
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   filling;

  list_tracker tracker = new;

  colc_in_if  #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_W)) in_ch ();
  colc_out_if #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_W)) out_ch ();

  compacting_ordered_list_core #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // results are checked before the new request is noted; a result never
  // belongs to a request taken at the same edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status      = status_t'(out_ch.status);
        got.entry_value = out_ch.entry_value;
        got.has_entry   = out_ch.has_entry;
        got.last        = out_ch.last;
        got.entry_count = out_ch.entry_count;
        tracker.match_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        tracker.apply_command(cmd_t'(in_ch.cmd), in_ch.value, in_ch.position);
    end
  end

  // called and returns at a falling edge; valid stays high for back-to-back requests
  task automatic send_request(cmd_t c, logic signed [VALUE_W-1:0] v, logic [CNT_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.value    <= v;
    in_ch.position <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 7) - 4;
    endcase
  endfunction

  // alternate between filling toward full and draining toward empty
  task automatic send_random();
    int                        roll;
    int                        w_app;
    int                        w_pos;
    int                        w_val;
    cmd_t                      c;
    logic signed [VALUE_W-1:0] v;
    logic [CNT_W-1:0]          p;
    if (filling && tracker.fill == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
    else if (!filling && tracker.fill == 0 && $urandom_range(2) == 0) filling = 1'b1;
    w_app = filling ? 65 : 15;
    w_pos = filling ? 75 : 50;
    w_val = filling ? 87 : 85;
    roll  = $urandom_range(99);
    c = (roll < w_app) ? CMD_APPEND : (roll < w_pos) ? CMD_DEL_POS :
        (roll < w_val) ? CMD_DEL_VAL : CMD_READ;
    v = $urandom;
    p = CNT_W'($urandom_range(0, 31));
    case (c)
      CMD_APPEND: v = pick_value();
      CMD_DEL_POS: begin
        if (tracker.fill > 0 && $urandom_range(3) != 0)
          p = CNT_W'($urandom_range(1, tracker.fill));
      end
      CMD_DEL_VAL: begin
        if (tracker.fill > 0 && $urandom_range(4) > 1) v = tracker.stored_value();
        else v = pick_value();
      end
      default: ;
    endcase
    send_request(c, v, p);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_APPEND;
    in_ch.value    = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    filling        = 1'b1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: read-out gives one empty result, deletes find nothing
    send_request(CMD_READ, '1, '1);
    send_request(CMD_DEL_POS, '0, 5'd1);
    send_request(CMD_DEL_VAL, '0, '0);
    send_request(CMD_APPEND, 32'sh8000_0000, '0);
    send_request(CMD_APPEND, 32'sh7fff_ffff, '0);
    send_request(CMD_APPEND, '0, '0);
    send_request(CMD_APPEND, '1, '0);
    // position zero and beyond the tail
    send_request(CMD_DEL_POS, '0, 5'd0);
    send_request(CMD_DEL_POS, '1, 5'd31);
    send_request(CMD_DEL_VAL, 32'sd12345, '0);
    send_request(CMD_DEL_VAL, 32'sh7fff_ffff, '0);
    send_request(CMD_READ, '0, '0);
    // fill with repeated zeros, then append to a full list
    for (int i = 0; i < 13; i++) begin
      send_request(CMD_APPEND, (i % 2 == 0) ? 0 : i, '0);
    end
    send_request(CMD_APPEND, 32'sh5555_aaaa, '0);
    send_request(CMD_READ, '0, '0);
    send_request(CMD_DEL_POS, '0, 5'd16);
    drain();

    run_phase(0, 0, 110);
    run_phase(84, 0, 110);
    run_phase(0, 84, 110);
    run_phase(32, 32, 110);
    repeat (16) @(negedge clk);

    $display({"run covered %0d append, %0d delete-at-position, %0d delete-by-value",
              " and %0d read-out requests"},
             tracker.n_req[0], tracker.n_req[1], tracker.n_req[2], tracker.n_req[3]);
    $display("results checked: %0d, of which %0d list-full, %0d not-found, %0d list entries",
             tracker.n_results, tracker.n_full, tracker.n_missing, tracker.n_entries);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never came", tracker.errors,
               tracker.outstanding());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[compacting_ordered_list_core.f]
+incdir+rtl
rtl/colc_pkg.sv
rtl/colc_in_if.sv
rtl/colc_out_if.sv
rtl/colc_cell.sv
rtl/colc_obuf.sv
rtl/compacting_ordered_list_core.sv
tb/tb_compacting_ordered_list_core.sv
